// File: design/text_console_cursor_engine_unit_assert.svh
// Assertion macros for the text console cursor engine checker.
// Each macro wraps one clocked concurrent assertion with a reset disable.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define TCCE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TCCE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/tcce_pkg.sv
// Shared constants, command codes and types of the text console cursor engine.
// Used by the front, back and top level modules; depends on nothing else.
`default_nettype none

package tcce_pkg;

   localparam int COLS     = 80;
   localparam int ROWS     = 25;
   localparam int HIST     = 512;
   localparam int CELLS    = COLS * ROWS;
   localparam int HCELLS   = HIST * COLS;
   localparam int CELL_AW  = $clog2(CELLS);
   localparam int HIST_AW  = $clog2(HCELLS);
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;
   localparam int LINE_W   = 9;
   localparam int SLOT_W   = $clog2(HIST);
   localparam int QDEPTH   = 2;
   localparam int QAW      = 1;

   localparam logic [7:0] CH_NEWLINE   = 8'd10;
   localparam logic [7:0] CH_BACKSPACE = 8'd8;
   localparam logic [7:0] CH_TAB       = 8'd9;
   localparam logic [7:0] CH_SPACE     = 8'd32;
   localparam logic [7:0] RESET_ATTR   = 8'h0F;

   localparam logic [1:0] MODE_PUT     = 2'd0;
   localparam logic [1:0] MODE_CLEAR   = 2'd1;
   localparam logic [1:0] MODE_RDSCR   = 2'd2;
   localparam logic [1:0] MODE_RDHIS   = 2'd3;

   localparam logic [2:0] K_NOP        = 3'd0;
   localparam logic [2:0] K_PUT        = 3'd1;
   localparam logic [2:0] K_CLEAR      = 3'd2;
   localparam logic [2:0] K_RDSCR      = 3'd3;
   localparam logic [2:0] K_RDHIS      = 3'd4;

   localparam logic REG_FB   = 1'b0;
   localparam logic REG_ATTR = 1'b1;

   typedef struct packed {
      logic [2:0]          kind;
      logic [7:0]          ch;
      logic [CELL_AW-1:0]  scr_addr;
      logic [HIST_AW-1:0]  hist_addr;
      logic [LINE_W-1:0]   line;
      logic                rd_ok;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } back_ctl_type;

endpackage

`default_nettype wire

// File: design/text_console_cursor_engine_unit.sv
// Request words are queued; the back part executes the queue head and registers its
// response, for a read after a wait in S_RDWAIT. Puts sustain one word per cycle while
// no scroll or clear runs and the response does not stall. A scroll walks the screen
// memory through its single write port; clear writes one cell per cycle and loads its
// response with the last cell. Reset: synchronous; then a pass blanks the screen with
// attribute 15, in which no request word is accepted (register writes still are).
`default_nettype none

module text_console_cursor_engine_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // char_code, cell_row, cell_col, history_line
   input  wire logic [1:0]  req_tuser,  // mode
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,  // row_now, column_now, cell_char, cell_attribute,
                                        // history_write_index, scrolled
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data
);

   logic                   fb_ff;
   logic [7:0]             attr_ff;
   logic                   head_valid;
   tcce_pkg::cmd_type      head;
   tcce_pkg::back_ctl_type ctl;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff   <= 1'b1;
         attr_ff <= tcce_pkg::RESET_ATTR;
      end else if (csr_valid) begin
         case (csr_index)
            tcce_pkg::REG_FB: begin
               fb_ff <= csr_data[0];
            end
            tcce_pkg::REG_ATTR: begin
               attr_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   tcce_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .framebuffer_mode (fb_ff),
      .ctl              (ctl),
      .head_valid       (head_valid),
      .head             (head)
   );

   tcce_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head           (head),
      .ctl            (ctl),
      .text_attribute (attr_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

endmodule

`default_nettype wire

// File: design/tcce_front.sv
// Front part: accepts request words, classifies them into commands and
// queues them for the back part. Depends on tcce_pkg.
`default_nettype none

module tcce_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,  // char_code, cell_row, cell_col, history_line
   input  wire logic [1:0]            req_tuser,  // mode
   input  wire logic                  framebuffer_mode,
   input  wire tcce_pkg::back_ctl_type ctl,
   output logic                       head_valid,
   output tcce_pkg::cmd_type          head
);

   tcce_pkg::cmd_type       q_ff [tcce_pkg::QDEPTH];
   logic [tcce_pkg::QAW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [tcce_pkg::QAW:0]   cnt_ff, cnt_in;
   tcce_pkg::cmd_type       cmd;
   logic                    push;

   logic [7:0]                    f_ch;
   logic [tcce_pkg::ROW_W-1:0]    f_row;
   logic [tcce_pkg::COL_W-1:0]    f_col;
   logic [tcce_pkg::LINE_W-1:0]   f_line;

   assign f_ch   = req_tdata[7:0];
   assign f_row  = req_tdata[12:8];
   assign f_col  = req_tdata[19:13];
   assign f_line = req_tdata[28:20];

   always_comb begin
      cmd.ch        = f_ch;
      cmd.line      = f_line;
      cmd.scr_addr  = tcce_pkg::CELL_AW'(f_row * tcce_pkg::COLS)
                      + tcce_pkg::CELL_AW'(f_col);
      cmd.hist_addr = tcce_pkg::HIST_AW'(f_line * tcce_pkg::COLS)
                      + tcce_pkg::HIST_AW'(f_col);
      cmd.rd_ok     = 1'b0;
      case (req_tuser)
         tcce_pkg::MODE_PUT: begin
            cmd.kind = framebuffer_mode ? tcce_pkg::K_NOP : tcce_pkg::K_PUT;
         end
         tcce_pkg::MODE_CLEAR: begin
            cmd.kind = tcce_pkg::K_CLEAR;
         end
         tcce_pkg::MODE_RDSCR: begin
            cmd.kind  = tcce_pkg::K_RDSCR;
            cmd.rd_ok = ({1'b0, f_row} < (tcce_pkg::ROW_W+1)'(tcce_pkg::ROWS))
                        && ({1'b0, f_col} < (tcce_pkg::COL_W+1)'(tcce_pkg::COLS));
         end
         default: begin
            cmd.kind  = tcce_pkg::K_RDHIS;
            cmd.rd_ok = ({1'b0, f_line} < (tcce_pkg::LINE_W+1)'(tcce_pkg::HIST))
                        && ({1'b0, f_col} < (tcce_pkg::COL_W+1)'(tcce_pkg::COLS));
         end
      endcase
   end

   assign req_tready = (cnt_ff != (tcce_pkg::QAW+1)'(tcce_pkg::QDEPTH)) && !ctl.init_busy;
   assign push       = req_tvalid && req_tready;
   assign head_valid = (cnt_ff != '0);
   assign head       = q_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in = wp_ff + 1'b1;
      end
      if (ctl.pop) begin
         rp_in = rp_ff + 1'b1;
      end
      if (push && !ctl.pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && ctl.pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cmd;
      end
   end

endmodule

`default_nettype wire

// File: design/tcce_back.sv
// Back part: executes queued commands against the screen and scrollback
// memories, keeps the cursor and drives the response register. Depends on tcce_pkg.
`default_nettype none

module tcce_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire tcce_pkg::cmd_type     head,
   output tcce_pkg::back_ctl_type     ctl,
   input  wire logic [7:0]            text_attribute,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [39:0]                rsp_tdata
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_HIST   = 3'd3;
   localparam logic [2:0] S_SHIFT  = 3'd4;
   localparam logic [2:0] S_SETTLE = 3'd5;
   localparam logic [2:0] S_BLANK  = 3'd6;
   localparam logic [2:0] S_FIN    = 3'd7;

   localparam int AW = tcce_pkg::CELL_AW;
   localparam int HW = tcce_pkg::HIST_AW;
   localparam int RW = tcce_pkg::ROW_W;
   localparam int CW = tcce_pkg::COL_W;
   localparam int SW = tcce_pkg::SLOT_W;

   logic [15:0] scr_mem [tcce_pkg::CELLS];
   logic [7:0]  his_mem [tcce_pkg::HCELLS];

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic          wrap_ff, wrap_in;
   logic          pput_ff, pput_in;
   logic [7:0]    pch_ff, pch_in;
   logic [7:0]    clr_attr_ff, clr_attr_in;
   logic          clr_report_ff, clr_report_in;
   logic          rd_his_ff, rd_his_in;
   logic          sd_we_ff, sd_we_in;
   logic [AW-1:0] sd_wa_ff, sd_wa_in;
   logic          hd_we_ff, hd_we_in;
   logic [HW-1:0] hd_wa_ff, hd_wa_in;
   logic [15:0]   scr_q_ff;
   logic [7:0]    his_q_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0] rsp_row_ff;
   logic [CW-1:0] rsp_col_ff;
   logic [7:0]    rsp_char_ff, rsp_attr_ff;
   logic [SW-1:0] rsp_slot_ff;
   logic          rsp_scr_ff;

   logic          scr_we;
   logic [AW-1:0] scr_wa, scr_ra;
   logic [15:0]   scr_wd;
   logic          load, res_scr, out_free, pop;
   logic [7:0]    res_char, res_attr;

   // put-character decode
   logic          nl, scroll, put_en, nl_col1;
   logic [RW-1:0] nrow, put_row;
   logic [CW-1:0] ncol, put_col;
   logic [7:0]    put_ch;
   logic [RW:0]   row_p1;
   logic [CW:0]   tabc;
   logic [AW-1:0] put_addr;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      nl      = 1'b0;
      nl_col1 = 1'b0;
      scroll  = 1'b0;
      put_en  = 1'b0;
      put_row = row_ff;
      put_col = col_ff;
      put_ch  = head.ch;
      nrow    = row_ff;
      ncol    = col_ff;
      row_p1  = {1'b0, row_ff} + 1'b1;
      tabc    = ({1'b0, col_ff} + (CW+1)'(8)) & ~(CW+1)'(7);
      case (head.ch)
         tcce_pkg::CH_NEWLINE: begin
            nl = 1'b1;
         end
         tcce_pkg::CH_BACKSPACE: begin
            put_ch = tcce_pkg::CH_SPACE;
            if (col_ff != '0) begin
               ncol    = col_ff - 1'b1;
               put_col = col_ff - 1'b1;
               put_en  = 1'b1;
            end else if (row_ff != '0) begin
               nrow    = row_ff - 1'b1;
               ncol    = CW'(tcce_pkg::COLS - 1);
               put_row = row_ff - 1'b1;
               put_col = CW'(tcce_pkg::COLS - 1);
               put_en  = 1'b1;
            end
         end
         tcce_pkg::CH_TAB: begin
            if (tabc >= (CW+1)'(tcce_pkg::COLS)) begin
               nl = 1'b1;
            end else begin
               ncol = tabc[CW-1:0];
            end
         end
         default: begin
            put_en = 1'b1;
            if ({1'b0, col_ff} >= (CW+1)'(tcce_pkg::COLS)) begin
               nl      = 1'b1;
               nl_col1 = 1'b1;
               put_col = '0;
            end else begin
               ncol = col_ff + 1'b1;
            end
         end
      endcase
      if (nl) begin
         ncol = nl_col1 ? CW'(1) : '0;
         if (row_p1 >= (RW+1)'(tcce_pkg::ROWS)) begin
            scroll = 1'b1;
            nrow   = RW'(tcce_pkg::ROWS - 1);
         end else begin
            nrow = row_p1[RW-1:0];
         end
         put_row = nrow;
      end
      put_addr = AW'(put_row * tcce_pkg::COLS) + AW'(put_col);
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      slot_in       = slot_ff;
      wrap_in       = wrap_ff;
      pput_in       = pput_ff;
      pch_in        = pch_ff;
      clr_attr_in   = clr_attr_ff;
      clr_report_in = clr_report_ff;
      rd_his_in     = rd_his_ff;
      sd_we_in      = 1'b0;
      sd_wa_in      = cnt_ff;
      hd_we_in      = 1'b0;
      hd_wa_in      = hd_wa_ff;
      scr_we        = 1'b0;
      scr_wa        = cnt_ff;
      scr_wd        = {text_attribute, tcce_pkg::CH_SPACE};
      scr_ra        = head.scr_addr;
      load          = 1'b0;
      res_scr       = 1'b0;
      res_char      = '0;
      res_attr      = '0;
      pop           = 1'b0;

      // The delayed write of a shifted cell owns the port for that cycle.
      if (sd_we_ff) begin
         scr_we = 1'b1;
         scr_wa = sd_wa_ff;
         scr_wd = scr_q_ff;
      end

      case (state_ff)
         S_CLEAR: begin
            scr_we = 1'b1;
            scr_wa = cnt_ff;
            scr_wd = {clr_attr_ff, tcce_pkg::CH_SPACE};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == AW'(tcce_pkg::CELLS - 1)) begin
               state_in      = S_IDLE;
               clr_report_in = 1'b0;
               load          = clr_report_ff;
            end
         end
         S_IDLE: begin
            if (head_valid && out_free) begin
               pop = 1'b1;
               case (head.kind)
                  tcce_pkg::K_PUT: begin
                     row_in = nrow;
                     col_in = ncol;
                     if (scroll) begin
                        state_in = S_HIST;
                        cnt_in   = '0;
                        pput_in  = put_en;
                        pch_in   = put_ch;
                     end else begin
                        scr_we = put_en;
                        scr_wa = put_addr;
                        scr_wd = {text_attribute, put_ch};
                        load   = 1'b1;
                     end
                  end
                  tcce_pkg::K_CLEAR: begin
                     row_in        = '0;
                     col_in        = '0;
                     cnt_in        = '0;
                     clr_attr_in   = text_attribute;
                     clr_report_in = 1'b1;
                     state_in      = S_CLEAR;
                  end
                  tcce_pkg::K_RDSCR: begin
                     rd_his_in = 1'b0;
                     if (head.rd_ok) begin
                        state_in = S_RDWAIT;
                     end else begin
                        load = 1'b1;
                     end
                  end
                  tcce_pkg::K_RDHIS: begin
                     rd_his_in = 1'b1;
                     // Lines never written are not read from memory; they answer zero.
                     if (head.rd_ok && (wrap_ff
                         || ({1'b0, head.line} < {1'b0, slot_ff}))) begin
                        state_in = S_RDWAIT;
                     end else begin
                        load = 1'b1;
                     end
                  end
                  default: begin
                     load = 1'b1;
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            load     = 1'b1;
            res_char = rd_his_ff ? his_q_ff : scr_q_ff[7:0];
            res_attr = rd_his_ff ? 8'd0 : scr_q_ff[15:8];
            state_in = S_IDLE;
         end
         S_HIST: begin
            scr_ra   = cnt_ff;
            hd_we_in = 1'b1;
            hd_wa_in = HW'(slot_ff * tcce_pkg::COLS) + HW'(cnt_ff);
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == AW'(tcce_pkg::COLS - 1)) begin
               cnt_in   = '0;
               state_in = S_SHIFT;
               if (slot_ff == SW'(tcce_pkg::HIST - 1)) begin
                  slot_in = '0;
                  wrap_in = 1'b1;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         S_SHIFT: begin
            scr_ra   = cnt_ff + AW'(tcce_pkg::COLS);
            sd_we_in = 1'b1;
            sd_wa_in = cnt_ff;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == AW'(tcce_pkg::CELLS - tcce_pkg::COLS - 1)) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            cnt_in   = AW'(tcce_pkg::CELLS - tcce_pkg::COLS);
            state_in = S_BLANK;
         end
         S_BLANK: begin
            scr_we = 1'b1;
            scr_wa = cnt_ff;
            scr_wd = {text_attribute, tcce_pkg::CH_SPACE};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == AW'(tcce_pkg::CELLS - 1)) begin
               state_in = S_FIN;
            end
         end
         default: begin
            // S_FIN: a character that caused the scroll lands at the bottom left.
            scr_we   = pput_ff;
            scr_wa   = AW'((tcce_pkg::ROWS - 1) * tcce_pkg::COLS);
            scr_wd   = {text_attribute, pch_ff};
            pput_in  = 1'b0;
            load     = 1'b1;
            res_scr  = 1'b1;
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign ctl.pop       = pop;
   assign ctl.init_busy = (state_ff == S_CLEAR) && !clr_report_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         cnt_ff        <= '0;
         row_ff        <= '0;
         col_ff        <= '0;
         slot_ff       <= '0;
         wrap_ff       <= 1'b0;
         pput_ff       <= 1'b0;
         clr_attr_ff   <= tcce_pkg::RESET_ATTR;
         clr_report_ff <= 1'b0;
         rd_his_ff     <= 1'b0;
         sd_we_ff      <= 1'b0;
         hd_we_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         slot_ff       <= slot_in;
         wrap_ff       <= wrap_in;
         pput_ff       <= pput_in;
         clr_attr_ff   <= clr_attr_in;
         clr_report_ff <= clr_report_in;
         rd_his_ff     <= rd_his_in;
         sd_we_ff      <= sd_we_in;
         hd_we_ff      <= hd_we_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pch_ff   <= pch_in;
      sd_wa_ff <= sd_wa_in;
      hd_wa_ff <= hd_wa_in;
      if (load) begin
         rsp_row_ff  <= row_in;
         rsp_col_ff  <= col_in;
         rsp_char_ff <= res_char;
         rsp_attr_ff <= res_attr;
         rsp_slot_ff <= slot_in;
         rsp_scr_ff  <= res_scr;
      end
   end

   always_ff @(posedge clock) begin
      if (scr_we) begin
         scr_mem[scr_wa] <= scr_wd;
      end
      scr_q_ff <= scr_mem[scr_ra];
   end

   always_ff @(posedge clock) begin
      if (hd_we_ff) begin
         his_mem[hd_wa_ff] <= scr_q_ff[7:0];
      end
      his_q_ff <= his_mem[head.hist_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_scr_ff, rsp_slot_ff, rsp_attr_ff, rsp_char_ff,
                        rsp_col_ff, rsp_row_ff};

endmodule

`default_nettype wire

// File: design/tcce_checker.sv
// Port-level checker for the text console cursor engine, bound to the top level.
// Depends on text_console_cursor_engine_unit_assert.svh.
`default_nettype none
`include "text_console_cursor_engine_unit_assert.svh"

module tcce_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   `TCCE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "response word dropped while stalled")
   `TCCE_ASSERT_NOW(a_row_range, clock, reset, rsp_tvalid, rsp_tdata[4:0] <= 5'd24, "cursor row off screen")
   `TCCE_ASSERT_NOW(a_col_range, clock, reset, rsp_tvalid, rsp_tdata[11:5] <= 7'd80, "cursor column beyond pending wrap")
   `TCCE_ASSERT_NOW(a_scroll_row, clock, reset, rsp_tvalid && rsp_tdata[37], rsp_tdata[4:0] == 5'd24, "scroll left cursor above bottom row")

endmodule

bind text_console_cursor_engine_unit tcce_checker u_checker (.*);

`default_nettype wire

// File: tb/text_console_cursor_engine_unit_checker.sv
// Checker for the text console cursor engine: watches the command, response and
// register channels, predicts every response and compares it. Depends on tcce_pkg.
`timescale 1ns / 100ps
`default_nettype none

module text_console_cursor_engine_unit_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [39:0] rsp_tdata,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_data,
   output int               errors,
   output int               pending
);

   typedef struct {
      logic [4:0] row;
      logic [6:0] col;
      logic [7:0] ch;
      logic [7:0] attr;
      logic [8:0] slot;
      logic       scrolled;
   } console_view_type;

   logic [7:0] scr_ch [0:tcce_pkg::CELLS-1];
   logic [7:0] scr_at [0:tcce_pkg::CELLS-1];
   logic [7:0] hist_ch [0:tcce_pkg::HCELLS-1];
   int cur_row, cur_col, wr_slot;
   logic fb_mode;
   logic [7:0] attr_now;
   console_view_type views_due[$];

   assign pending = views_due.size();

   task blank_screen;
      for (int i = 0; i < tcce_pkg::CELLS; i++) begin
         scr_ch[i] = tcce_pkg::CH_SPACE;
         scr_at[i] = attr_now;
      end
      cur_row = 0;
      cur_col = 0;
   endtask

   task scroll_screen;
      for (int c = 0; c < tcce_pkg::COLS; c++)
         hist_ch[wr_slot * tcce_pkg::COLS + c] = scr_ch[c];
      wr_slot = (wr_slot + 1) % tcce_pkg::HIST;
      for (int i = 0; i < tcce_pkg::CELLS - tcce_pkg::COLS; i++) begin
         scr_ch[i] = scr_ch[i + tcce_pkg::COLS];
         scr_at[i] = scr_at[i + tcce_pkg::COLS];
      end
      for (int i = tcce_pkg::CELLS - tcce_pkg::COLS; i < tcce_pkg::CELLS; i++) begin
         scr_ch[i] = tcce_pkg::CH_SPACE;
         scr_at[i] = attr_now;
      end
   endtask

   task line_feed(output logic sc);
      sc = 1'b0;
      cur_col = 0;
      cur_row++;
      if (cur_row >= tcce_pkg::ROWS) begin
         cur_row = tcce_pkg::ROWS - 1;
         scroll_screen();
         sc = 1'b1;
      end
   endtask

   task draw_cell(input logic [7:0] ch);
      int pos;
      pos = cur_row * tcce_pkg::COLS + cur_col;
      if (pos < tcce_pkg::CELLS) begin
         scr_ch[pos] = ch;
         scr_at[pos] = attr_now;
      end
   endtask

   task put_character(input logic [7:0] ch, output logic sc);
      sc = 1'b0;
      if (ch == tcce_pkg::CH_NEWLINE) begin
         line_feed(sc);
      end else if (ch == tcce_pkg::CH_BACKSPACE) begin
         if (cur_col > 0) begin
            cur_col--;
            draw_cell(tcce_pkg::CH_SPACE);
         end else if (cur_row > 0) begin
            cur_row--;
            cur_col = tcce_pkg::COLS - 1;
            draw_cell(tcce_pkg::CH_SPACE);
         end
      end else if (ch == tcce_pkg::CH_TAB) begin
         cur_col = (cur_col + 8) & ~7;
         if (cur_col >= tcce_pkg::COLS) line_feed(sc);
      end else begin
         if (cur_col >= tcce_pkg::COLS) line_feed(sc);
         draw_cell(ch);
         cur_col++;
      end
   endtask

   task run_command(input logic [1:0] mode, input logic [31:0] word,
                    output console_view_type v);
      logic [7:0] ch;
      int row, col, line;
      ch = word[7:0];
      row = int'(word[12:8]);
      col = int'(word[19:13]);
      line = int'(word[28:20]);
      v.ch = '0;
      v.attr = '0;
      v.scrolled = 1'b0;
      case (mode)
         tcce_pkg::MODE_PUT: begin
            if (!fb_mode) put_character(ch, v.scrolled);
         end
         tcce_pkg::MODE_CLEAR: begin
            blank_screen();
         end
         tcce_pkg::MODE_RDSCR: begin
            if (row < tcce_pkg::ROWS && col < tcce_pkg::COLS) begin
               v.ch = scr_ch[row * tcce_pkg::COLS + col];
               v.attr = scr_at[row * tcce_pkg::COLS + col];
            end
         end
         default: begin
            if (line < tcce_pkg::HIST && col < tcce_pkg::COLS)
               v.ch = hist_ch[line * tcce_pkg::COLS + col];
         end
      endcase
      v.row = 5'(cur_row);
      v.col = 7'(cur_col);
      v.slot = 9'(wr_slot);
   endtask

   always @(posedge clock) begin
      console_view_type v, want;
      if (reset) begin
         fb_mode = 1'b1;
         attr_now = tcce_pkg::RESET_ATTR;
         blank_screen();
         for (int i = 0; i < tcce_pkg::HCELLS; i++) hist_ch[i] = '0;
         wr_slot = 0;
         views_due.delete();
         errors <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == tcce_pkg::REG_FB) fb_mode = csr_data[0];
            else attr_now = csr_data;
         end
         if (req_tvalid && req_tready) begin
            run_command(req_tuser, req_tdata, v);
            views_due.push_back(v);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (views_due.size() == 0) begin
               if (errors < 10)
                  $display("response word with nothing expected: %h", rsp_tdata);
               errors <= errors + 1;
            end else begin
               want = views_due.pop_front();
               if (rsp_tdata[4:0] !== want.row || rsp_tdata[11:5] !== want.col ||
                   rsp_tdata[19:12] !== want.ch || rsp_tdata[27:20] !== want.attr ||
                   rsp_tdata[36:28] !== want.slot || rsp_tdata[37] !== want.scrolled) begin
                  if (errors < 10)
                     $display({"mismatch: row %0d/%0d col %0d/%0d char %h/%h attr %h/%h",
                               " slot %0d/%0d scrolled %b/%b (expected/actual)"},
                              want.row, rsp_tdata[4:0], want.col, rsp_tdata[11:5],
                              want.ch, rsp_tdata[19:12], want.attr, rsp_tdata[27:20],
                              want.slot, rsp_tdata[36:28], want.scrolled, rsp_tdata[37]);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: tb/text_console_cursor_engine_unit_tb.sv
// Top of the text console cursor engine testbench: clock, reset, commands and
// register writes, with the checker beside the block. Depends on tcce_pkg.
`timescale 1ns / 100ps
`default_nettype none

module text_console_cursor_engine_unit_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [7:0] csr_data = '0;
   int errors, pending;

   // Idling is switched off for the last phase; the long hold happens once.
   logic quiet = 1'b0;
   logic hold_go = 1'b0;
   logic hold_done = 1'b0;
   int hold_count = 0;
   int stall_left = 0;

   always #5 clock = ~clock;

   text_console_cursor_engine_unit dut (.*);

   text_console_cursor_engine_unit_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count++;
         if (hold_count == 400) hold_done = 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 14);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task send_command(input logic [1:0] mode, input logic [7:0] ch, input logic [4:0] row,
                     input logic [6:0] col, input logic [8:0] line);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {3'b000, line, col, row, ch};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task put_char(input logic [7:0] ch);
      send_command(tcce_pkg::MODE_PUT, ch, '0, '0, '0);
   endtask

   // Stops sending and waits for every outstanding response before going on.
   task drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task write_reg(input logic idx, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task random_command;
      int pick;
      logic [7:0] ch;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         case ($urandom_range(0, 19))
            0: ch = tcce_pkg::CH_NEWLINE;
            1: ch = tcce_pkg::CH_BACKSPACE;
            2: ch = tcce_pkg::CH_TAB;
            3, 4: ch = 8'($urandom_range(0, 255));
            default: ch = 8'($urandom_range(32, 126));
         endcase
         put_char(ch);
      end else if (pick < 57) begin
         send_command(tcce_pkg::MODE_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom),
                      9'($urandom));
      end else if (pick < 85) begin
         // Mostly in range, with the odd read outside the screen.
         if ($urandom_range(0, 7) == 0)
            send_command(tcce_pkg::MODE_RDSCR, 8'($urandom), 5'($urandom), 7'($urandom),
                         9'($urandom));
         else
            send_command(tcce_pkg::MODE_RDSCR, 8'($urandom),
                         5'($urandom_range(0, tcce_pkg::ROWS - 1)),
                         7'($urandom_range(0, tcce_pkg::COLS - 1)), 9'($urandom));
      end else begin
         if ($urandom_range(0, 7) == 0)
            send_command(tcce_pkg::MODE_RDHIS, 8'($urandom), 5'($urandom), 7'($urandom),
                         9'($urandom));
         else
            send_command(tcce_pkg::MODE_RDHIS, 8'($urandom), 5'($urandom),
                         7'($urandom_range(0, tcce_pkg::COLS - 1)),
                         9'($urandom_range(0, 7)));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_reg(tcce_pkg::REG_FB, 8'd0);
      write_reg(tcce_pkg::REG_ATTR, 8'h5A);

      // Backspace at home, then the character extremes.
      put_char(tcce_pkg::CH_BACKSPACE);
      put_char(8'h00);
      put_char(8'hFF);
      put_char("A");
      // Tabs run off the end of the row and onto the next line.
      repeat (10) put_char(tcce_pkg::CH_TAB);
      send_command(tcce_pkg::MODE_RDSCR, 8'h00, 5'd0, 7'd1, 9'd0);
      send_command(tcce_pkg::MODE_RDSCR, 8'hFF, 5'd31, 7'd127, 9'h1FF);
      send_command(tcce_pkg::MODE_RDHIS, 8'hFF, 5'd31, 7'd127, 9'd511);
      send_command(tcce_pkg::MODE_CLEAR, 8'h00, 5'd0, 7'd0, 9'd0);
      // A full row leaves a pending wrap; backspace takes it back to the last column.
      repeat (tcce_pkg::COLS) put_char("x");
      put_char(tcce_pkg::CH_BACKSPACE);
      put_char("y");
      put_char("z");
      repeat (tcce_pkg::ROWS) put_char(tcce_pkg::CH_NEWLINE);
      send_command(tcce_pkg::MODE_RDHIS, 8'h00, 5'd0, 7'd0, 9'd0);
      send_command(tcce_pkg::MODE_RDSCR, 8'h00, 5'd24, 7'd79, 9'd0);
      drain();
      write_reg(tcce_pkg::REG_FB, 8'd1);
      put_char("Q");
      send_command(tcce_pkg::MODE_CLEAR, 8'h00, 5'd0, 7'd0, 9'd0);
      send_command(tcce_pkg::MODE_RDSCR, 8'h00, 5'd0, 7'd0, 9'd0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_reg(tcce_pkg::REG_FB, 8'd0);
               write_reg(tcce_pkg::REG_ATTR, 8'h00);
            end
            1: write_reg(tcce_pkg::REG_ATTR, 8'hFF);
            2: begin
               write_reg(tcce_pkg::REG_FB, 8'd1);
               write_reg(tcce_pkg::REG_ATTR, 8'($urandom));
            end
            default: begin
               write_reg(tcce_pkg::REG_FB, 8'd0);
               write_reg(tcce_pkg::REG_ATTR, 8'($urandom));
               quiet <= 1'b1;
            end
         endcase
         for (int n = 0; n < 195; n++) begin
            if (phase == 0 && n == 20) hold_go <= 1'b1;
            random_command();
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("text_console_cursor_engine_unit_tb: done, clean");
      else
         $display("text_console_cursor_engine_unit_tb: done, errors");
      $finish;
   end

   initial begin
      #100ms;
      $display("text_console_cursor_engine_unit_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+design
design/tcce_pkg.sv
design/tcce_front.sv
design/tcce_back.sv
design/text_console_cursor_engine_unit.sv
design/tcce_checker.sv
tb/text_console_cursor_engine_unit_checker.sv
tb/text_console_cursor_engine_unit_tb.sv
